// ===== rtl/binary_image_component_counter_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the binary image component counter
// Shared property forms used by the bicc_engine RTL module
// ---------------------------------------------------------------------------
`ifndef BINARY_IMAGE_COMPONENT_COUNTER_CORE_ASSERT_SVH
`define BINARY_IMAGE_COMPONENT_COUNTER_CORE_ASSERT_SVH

// same-cycle implication under reset
`define BICC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define BICC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bicc_pkg.sv =====
// ---------------------------------------------------------------------------
// bicc_pkg
// Types, constants and helpers for the binary image component counter
// ---------------------------------------------------------------------------
package bicc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = COL_W + 1;
    localparam int CNT_W       = 32;
    localparam int GRP_W       = 4;
    localparam int CR_DEPTH    = MAX_WIDTH / GRP_W;
    localparam int CR_AW       = $clog2(CR_DEPTH);
    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(MAX_WIDTH);
    localparam logic [WID_W-1:0] WIDTH_MIN   = WID_W'(GRP_W);

    // root mark kinds
    typedef enum logic [1:0] {
        MK_NONE,
        MK_COL,
        MK_CLOSED
    } mark_kind_t;

    typedef struct packed {
        mark_kind_t         kind;
        logic [COL_W-1:0]   col;
    } mark_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P1_RD,
        ST_P1_CHK,
        ST_P1_MK,
        ST_P2_RD,
        ST_P2_CHK,
        ST_P2_MK,
        ST_MC,
        ST_P3_RD,
        ST_P3_CHK,
        ST_FL_RD,
        ST_FL_PAR,
        ST_FL_LAB,
        ST_DONE,
        ST_J_A,
        ST_J_B
    } state_t;

    // request from the top level
    typedef struct packed {
        logic               start;
        logic [GRP_W-1:0]   group;
        logic               last;
    } req_t;

    // status back to the top level
    typedef struct packed {
        logic               ready;
        logic               done;
        logic [CNT_W-1:0]   count;
    } rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/bicc_engine.sv =====
// ---------------------------------------------------------------------------
// bicc_engine
// Row buffers, union-find label memories and the row-end pass sequencer
// ---------------------------------------------------------------------------
`include "binary_image_component_counter_core_assert.svh"

module bicc_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bicc_pkg::req_t              req,
    input  logic [bicc_pkg::WID_W-1:0]  width,
    input  logic                        out_free,
    output bicc_pkg::rsp_t              rsp
);

    localparam int CW = bicc_pkg::COL_W;
    localparam int WW = bicc_pkg::WID_W;
    localparam int AW = bicc_pkg::CR_AW;

    // memories
    logic [bicc_pkg::GRP_W-1:0] cr_mem [0:bicc_pkg::CR_DEPTH-1];
    logic [CW:0]                pv_mem [0:bicc_pkg::MAX_WIDTH-1];
    logic [CW-1:0]              cp_mem [0:bicc_pkg::MAX_WIDTH-1];
    bicc_pkg::mark_t            mk_mem [0:bicc_pkg::MAX_WIDTH-1];

    logic                       cr_we;
    logic [AW-1:0]              cr_waddr, cr_raddr;
    logic [bicc_pkg::GRP_W-1:0] cr_wdata, cr_rdata;
    logic                       pv_we;
    logic [CW-1:0]              pv_waddr, pv_raddr;
    logic [CW:0]                pv_wdata, pv_rdata;
    logic                       cp_we;
    logic [CW-1:0]              cp_waddr, cp_raddr, cp_wdata, cp_rdata;
    logic                       mk_we;
    logic [CW-1:0]              mk_waddr, mk_raddr;
    bicc_pkg::mark_t            mk_wdata, mk_rdata;

    // registers
    bicc_pkg::state_t           state_reg, state_next;
    bicc_pkg::state_t           ret_reg, ret_next;
    logic [WW-1:0]              j_reg, j_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [WW-1:0]              fill_reg, fill_next;
    logic [WW-1:0]              w_reg, w_next;
    logic [WW-1:0]              prev_w_reg, prev_w_next;
    logic                       last_reg, last_next;
    logic [bicc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]              ja_reg, ja_next;
    logic [CW-1:0]              jb_reg, jb_next;
    logic [CW-1:0]              ra_reg, ra_next;
    logic [CW-1:0]              x_reg, x_next;
    logic [CW-1:0]              lab_reg, lab_next;
    logic                       cprev_reg, cprev_next;
    logic                       cbit_reg, cbit_next;

    // shared decode
    logic [CW-1:0]              j12;
    logic [1:0]                 bsel;
    logic                       curbit, prevbit;
    logic [CW-1:0]              prevlab;
    logic [WW-1:0]              sum;
    logic                       row_end;
    logic                       j_end, mc_end;
    logic                       mk_none, par_root, p1_hit, p3_hit;

    assign j12      = j_reg[CW-1:0];
    assign bsel     = ~j_reg[1:0];
    assign curbit   = (j_reg < fill_reg) && cr_rdata[bsel];
    assign prevbit  = (j_reg < prev_w_reg) && pv_rdata[CW];
    assign prevlab  = pv_rdata[CW-1:0];
    assign sum      = {1'b0, col_reg} + WW'(bicc_pkg::GRP_W);
    assign row_end  = (sum >= width) || req.last;
    assign j_end    = (j_reg >= w_reg);
    assign mc_end   = (j_reg >= prev_w_reg);
    assign mk_none  = (mk_rdata.kind == bicc_pkg::MK_NONE);
    assign par_root = (cp_rdata == x_reg);
    assign p1_hit   = curbit && prevbit;
    assign p3_hit   = curbit && cprev_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bicc_pkg::ST_CLEAR:  if (j_reg[CW]) state_next = bicc_pkg::ST_IDLE;
            bicc_pkg::ST_IDLE:   if (req.start && row_end) state_next = bicc_pkg::ST_P1_RD;
            bicc_pkg::ST_P1_RD:  state_next = j_end ? bicc_pkg::ST_P2_RD : bicc_pkg::ST_P1_CHK;
            bicc_pkg::ST_P1_CHK: state_next = p1_hit ? bicc_pkg::ST_P1_MK : bicc_pkg::ST_P1_RD;
            bicc_pkg::ST_P1_MK:  state_next = mk_none ? bicc_pkg::ST_P1_RD : bicc_pkg::ST_J_A;
            bicc_pkg::ST_P2_RD:  state_next = j_end ? bicc_pkg::ST_MC : bicc_pkg::ST_P2_CHK;
            bicc_pkg::ST_P2_CHK: state_next = prevbit ? bicc_pkg::ST_P2_MK : bicc_pkg::ST_P2_RD;
            bicc_pkg::ST_P2_MK:  state_next = bicc_pkg::ST_P2_RD;
            bicc_pkg::ST_MC:     if (mc_end) state_next = bicc_pkg::ST_P3_RD;
            bicc_pkg::ST_P3_RD:  state_next = j_end ? bicc_pkg::ST_FL_RD : bicc_pkg::ST_P3_CHK;
            bicc_pkg::ST_P3_CHK: state_next = p3_hit ? bicc_pkg::ST_J_A : bicc_pkg::ST_P3_RD;
            bicc_pkg::ST_FL_RD:
            begin
                if (!j_end)
                    state_next = bicc_pkg::ST_FL_PAR;
                else if (last_reg)
                    state_next = bicc_pkg::ST_DONE;
                else
                    state_next = bicc_pkg::ST_IDLE;
            end
            bicc_pkg::ST_FL_PAR: state_next = (cp_rdata == j12) ? bicc_pkg::ST_FL_RD
                                                                : bicc_pkg::ST_FL_LAB;
            bicc_pkg::ST_FL_LAB: state_next = bicc_pkg::ST_FL_RD;
            bicc_pkg::ST_DONE:   if (out_free) state_next = bicc_pkg::ST_IDLE;
            bicc_pkg::ST_J_A:    if (par_root) state_next = bicc_pkg::ST_J_B;
            bicc_pkg::ST_J_B:    if (par_root) state_next = ret_reg;
            default:             state_next = bicc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        ret_next    = ret_reg;
        j_next      = j_reg;
        col_next    = col_reg;
        fill_next   = fill_reg;
        w_next      = w_reg;
        prev_w_next = prev_w_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        ja_next     = ja_reg;
        jb_next     = jb_reg;
        ra_next     = ra_reg;
        x_next      = x_reg;
        lab_next    = lab_reg;
        cprev_next  = cprev_reg;
        cbit_next   = cbit_reg;
        cr_we       = 1'b0;
        cr_waddr    = col_reg[CW-1:2];
        cr_wdata    = req.group;
        cr_raddr    = j_reg[CW-1:2];
        pv_we       = 1'b0;
        pv_waddr    = j12;
        pv_wdata    = {1'b0, j12};
        pv_raddr    = j12;
        cp_we       = 1'b0;
        cp_waddr    = j12;
        cp_wdata    = j12;
        cp_raddr    = j12;
        mk_we       = 1'b0;
        mk_waddr    = lab_reg;
        mk_wdata    = '{kind: bicc_pkg::MK_NONE, col: '0};
        mk_raddr    = prevlab;
        rsp.ready   = 1'b0;
        rsp.done    = 1'b0;
        rsp.count   = count_reg;
        case (state_reg)
            // power-up sweep: parents to self, marks cleared
            bicc_pkg::ST_CLEAR:
            begin
                if (!j_reg[CW])
                begin
                    cp_we    = 1'b1;
                    mk_we    = 1'b1;
                    mk_waddr = j12;
                    j_next   = j_reg + WW'(1);
                end
                else
                begin
                    j_next = '0;
                end
            end
            // take pixel groups, detect row end
            bicc_pkg::ST_IDLE:
            begin
                rsp.ready = 1'b1;
                if (req.start)
                begin
                    cr_we = 1'b1;
                    if (row_end)
                    begin
                        w_next    = width;
                        fill_next = (sum > width) ? width : sum;
                        last_next = req.last;
                        j_next    = '0;
                        col_next  = '0;
                    end
                    else
                    begin
                        col_next = sum[CW-1:0];
                    end
                end
            end
            // pass 1: link new pixels through the component above
            bicc_pkg::ST_P1_RD:
            begin
                if (j_end)
                    j_next = '0;
            end
            bicc_pkg::ST_P1_CHK:
            begin
                lab_next = prevlab;
                if (!p1_hit)
                    j_next = j_reg + WW'(1);
            end
            bicc_pkg::ST_P1_MK:
            begin
                j_next = j_reg + WW'(1);
                if (mk_none)
                begin
                    mk_we    = 1'b1;
                    mk_wdata = '{kind: bicc_pkg::MK_COL, col: j12};
                end
                else
                begin
                    ja_next  = j12;
                    jb_next  = mk_rdata.col;
                    x_next   = j12;
                    cp_raddr = j12;
                    ret_next = bicc_pkg::ST_P1_RD;
                end
            end
            // pass 2: close components that do not continue
            bicc_pkg::ST_P2_RD:
            begin
                if (j_end)
                    j_next = '0;
            end
            bicc_pkg::ST_P2_CHK:
            begin
                lab_next = prevlab;
                if (!prevbit)
                    j_next = j_reg + WW'(1);
            end
            bicc_pkg::ST_P2_MK:
            begin
                j_next = j_reg + WW'(1);
                if (mk_none)
                begin
                    count_next = bicc_pkg::sat_inc(count_reg);
                    mk_we      = 1'b1;
                    mk_wdata   = '{kind: bicc_pkg::MK_CLOSED, col: '0};
                end
            end
            // sweep marks back to none
            bicc_pkg::ST_MC:
            begin
                if (mc_end)
                begin
                    j_next     = '0;
                    cprev_next = 1'b0;
                end
                else
                begin
                    mk_we    = 1'b1;
                    mk_waddr = j12;
                    j_next   = j_reg + WW'(1);
                end
            end
            // pass 3: merge horizontal neighbors
            bicc_pkg::ST_P3_RD:
            begin
                if (j_end)
                    j_next = '0;
            end
            bicc_pkg::ST_P3_CHK:
            begin
                cprev_next = curbit;
                j_next     = j_reg + WW'(1);
                if (p3_hit)
                begin
                    ja_next  = j12;
                    jb_next  = j12 - CW'(1);
                    x_next   = j12;
                    cp_raddr = j12;
                    ret_next = bicc_pkg::ST_P3_RD;
                end
            end
            // flatten: labels to roots, parents back to self
            bicc_pkg::ST_FL_RD:
            begin
                if (j_end)
                begin
                    prev_w_next = w_reg;
                    j_next      = '0;
                end
            end
            bicc_pkg::ST_FL_PAR:
            begin
                cp_we     = 1'b1;
                cbit_next = curbit;
                if (cp_rdata == j12)
                begin
                    pv_we    = 1'b1;
                    pv_wdata = {curbit, j12};
                    j_next   = j_reg + WW'(1);
                    if (last_reg && curbit)
                        count_next = bicc_pkg::sat_inc(count_reg);
                end
                else
                begin
                    pv_raddr = cp_rdata;
                end
            end
            bicc_pkg::ST_FL_LAB:
            begin
                pv_we    = 1'b1;
                pv_wdata = {cbit_reg, prevlab};
                j_next   = j_reg + WW'(1);
            end
            // hand out the total and drop the image state
            bicc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    rsp.done    = 1'b1;
                    count_next  = '0;
                    prev_w_next = '0;
                end
            end
            // join: walk to root of a, then b, link larger under smaller
            bicc_pkg::ST_J_A:
            begin
                if (par_root)
                begin
                    ra_next  = x_reg;
                    x_next   = jb_reg;
                    cp_raddr = jb_reg;
                end
                else
                begin
                    x_next   = cp_rdata;
                    cp_raddr = cp_rdata;
                end
            end
            bicc_pkg::ST_J_B:
            begin
                if (par_root)
                begin
                    if (ra_reg != x_reg)
                    begin
                        cp_we    = 1'b1;
                        cp_waddr = (ra_reg > x_reg) ? ra_reg : x_reg;
                        cp_wdata = (ra_reg > x_reg) ? x_reg : ra_reg;
                    end
                end
                else
                begin
                    x_next   = cp_rdata;
                    cp_raddr = cp_rdata;
                end
            end
            default:
            begin
                j_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bicc_pkg::ST_CLEAR;
            ret_reg    <= bicc_pkg::ST_IDLE;
            j_reg      <= '0;
            col_reg    <= '0;
            fill_reg   <= '0;
            w_reg      <= '0;
            prev_w_reg <= '0;
            last_reg   <= 1'b0;
            count_reg  <= '0;
            cprev_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            j_reg      <= j_next;
            col_reg    <= col_next;
            fill_reg   <= fill_next;
            w_reg      <= w_next;
            prev_w_reg <= prev_w_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
            cprev_reg  <= cprev_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        ja_reg   <= ja_next;
        jb_reg   <= jb_next;
        ra_reg   <= ra_next;
        x_reg    <= x_next;
        lab_reg  <= lab_next;
        cbit_reg <= cbit_next;
    end

    // current row pixels, one group per word
    always_ff @(posedge clk)
    begin
        if (cr_we)
            cr_mem[cr_waddr] <= cr_wdata;
        cr_rdata <= cr_mem[cr_raddr];
    end

    // previous row pixel and flattened root label
    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[pv_waddr] <= pv_wdata;
        pv_rdata <= pv_mem[pv_raddr];
    end

    // current row parent pointers
    always_ff @(posedge clk)
    begin
        if (cp_we)
            cp_mem[cp_waddr] <= cp_wdata;
        cp_rdata <= cp_mem[cp_raddr];
    end

    // marks on previous row roots
    always_ff @(posedge clk)
    begin
        if (mk_we)
            mk_mem[mk_waddr] <= mk_wdata;
        mk_rdata <= mk_mem[mk_raddr];
    end

    // checks
    `BICC_ASSERT_IMPLY(a_done_slot_free, clk, rst_n, rsp.done, out_free, "total with output busy")
    `BICC_ASSERT_IMPLY(a_parent_points_down, clk, rst_n, (state_reg == bicc_pkg::ST_FL_PAR), (cp_rdata <= j12), "parent above its own column")
    `BICC_ASSERT_NEXT(a_mid_row_ready, clk, rst_n, (req.start && !row_end), rsp.ready, "stalled inside a row")

endmodule

// ===== rtl/binary_image_component_counter_core.sv =====
// ---------------------------------------------------------------------------
// binary_image_component_counter_core
// Counts 4-connected components of set pixels in a streamed binary image
// ---------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request of four pixels
// (pixel_group, bit 3 leftmost) plus end_of_image on the final group.
// Output channel out_valid/out_ready carries component_count, one result per
// image, saturating at all ones. cfg_wr_en/cfg_wr_data write image_width; the user
// must write it only while the block is idle, which the block itself does not enforce.
// A group inside a row is taken in the idle state, so in_ready stays high. The group
// that ends a row starts the row-end sequencer, which walks the row through memories
// with one read and one write port: the link pass, the close pass, a mark sweep over
// the columns of the previous row, the merge pass and the flatten pass, plus parent
// hops during joins. in_ready stays low until the sequencer returns to idle.
// After reset a sweep over all 4096 columns initializes the parent and mark memories;
// in_ready stays low during it. The total sits in an output register; while
// the receiver stalls, the next image's groups are still taken, and only the
// final row end of the next image waits for the register to drain.
// ---------------------------------------------------------------------------
module binary_image_component_counter_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [3:0]                  pixel_group,
    input  logic                        end_of_image,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 component_count,
    input  logic                        cfg_wr_en,
    input  logic [12:0]                 cfg_wr_data
);

    logic [bicc_pkg::WID_W-1:0] width_reg;
    logic [bicc_pkg::WID_W-1:0] width_masked;
    logic [bicc_pkg::WID_W-1:0] width_eff;
    logic                       out_valid_reg, out_valid_next;
    logic [bicc_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       out_free;
    bicc_pkg::req_t             req;
    bicc_pkg::rsp_t             rsp;

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= bicc_pkg::WIDTH_RESET;
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    // usable width: whole groups, clamped to the supported range
    always_comb
    begin
        width_masked = {width_reg[bicc_pkg::WID_W-1:2], 2'b00};
        if (width_masked < bicc_pkg::WIDTH_MIN)
            width_eff = bicc_pkg::WIDTH_MIN;
        else if (width_masked > bicc_pkg::WIDTH_RESET)
            width_eff = bicc_pkg::WIDTH_RESET;
        else
            width_eff = width_masked;
    end

    // input request to the engine
    assign req.start = in_valid && rsp.ready;
    assign req.group = pixel_group;
    assign req.last  = end_of_image;
    assign in_ready  = rsp.ready;

    bicc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .width    (width_eff),
        .out_free (out_free),
        .rsp      (rsp)
    );

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (rsp.done)
        begin
            out_valid_next = 1'b1;
            count_next     = rsp.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign out_valid       = out_valid_reg;
    assign component_count = count_reg;

endmodule

// ===== test/bicc_checker.sv =====
// ---------------------------------------------------------------------------
// bicc_checker
// Watches the request, result and register ports of the component counter,
// keeps its own union-find image of the stream and checks every total
// ---------------------------------------------------------------------------
module bicc_checker
    import bicc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  pixel_group,
    input  logic        end_of_image,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] component_count,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    output int          errors,
    output int          pending
);

    localparam int NO_MARK     = -1;
    localparam int CLOSED_MARK = -2;

    bit          above_px [MAX_WIDTH];
    int          above_lab[MAX_WIDTH];
    bit          row_px   [MAX_WIDTH];
    int          row_lab  [MAX_WIDTH];
    int          owner    [MAX_WIDTH];
    logic [31:0] tally;
    int          col;
    logic [12:0] width_reg;
    logic [31:0] totals_q[$];

    assign pending = totals_q.size();

    // usable columns after masking and clamping
    function automatic int cols_in_use();
        int w;
        w = int'(width_reg) & ~3;
        if (w < 4) w = 4;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int root_above(int x);
        int r;
        int nx;
        r = x;
        while (above_lab[r] != r) r = above_lab[r];
        while (above_lab[x] != r)
        begin
            nx = above_lab[x];
            above_lab[x] = r;
            x = nx;
        end
        return r;
    endfunction

    function automatic int root_row(int x);
        int r;
        int nx;
        r = x;
        while (row_lab[r] != r) r = row_lab[r];
        while (row_lab[x] != r)
        begin
            nx = row_lab[x];
            row_lab[x] = r;
            x = nx;
        end
        return r;
    endfunction

    function automatic void merge_row(int a, int b);
        int ra;
        int rb;
        ra = root_row(a);
        rb = root_row(b);
        row_lab[ra] = rb;
    endfunction

    function automatic void bump();
        if (tally != 32'hFFFF_FFFF) tally = tally + 32'd1;
    endfunction

    function automatic void clear_image();
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            above_px[j] = 0;
            above_lab[j] = j;
            row_px[j] = 0;
            row_lab[j] = j;
        end
        tally = '0;
        col = 0;
    endfunction

    // count the components of the stored row that are not claimed
    function automatic void close_above(int w);
        int r;
        for (int j = 0; j < w; j++)
        begin
            if (above_px[j])
            begin
                r = root_above(j);
                if (owner[r] == NO_MARK)
                begin
                    bump();
                    owner[r] = CLOSED_MARK;
                end
            end
        end
    endfunction

    // link to the row above, close what ends, merge runs, shift rows
    function automatic void row_done(int w);
        int r;
        for (int j = 0; j < MAX_WIDTH; j++) owner[j] = NO_MARK;
        for (int j = 0; j < w; j++)
        begin
            if (row_px[j] && above_px[j])
            begin
                r = root_above(j);
                if (owner[r] == NO_MARK) owner[r] = j;
                else merge_row(j, owner[r]);
            end
        end
        close_above(w);
        for (int j = 1; j < w; j++)
            if (row_px[j] && row_px[j-1]) merge_row(j, j - 1);
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            above_px[j] = (j < w) ? row_px[j] : 1'b0;
            above_lab[j] = (j < w) ? row_lab[j] : j;
            row_px[j] = 0;
            row_lab[j] = j;
        end
        col = 0;
    endfunction

    function automatic void take_request(logic [3:0] g, logic last);
        int w;
        w = cols_in_use();
        for (int k = 0; k < 4; k++)
            if (col + k < w) row_px[col + k] = g[3 - k];
        if (col + 4 >= w || last) row_done(w);
        else col = col + 4;
        if (last)
        begin
            for (int j = 0; j < MAX_WIDTH; j++) owner[j] = NO_MARK;
            close_above(w);
            totals_q.push_back(tally);
            clear_image();
        end
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // model update and result compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = 13'd4096;
            clear_image();
            totals_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_wr_en) width_reg = cfg_wr_data;
            if (in_valid && in_ready) take_request(pixel_group, end_of_image);
            if (out_valid && out_ready)
            begin
                if (totals_q.size() == 0) report("unexpected total", component_count, '0);
                else
                begin
                    if (component_count !== totals_q[0])
                        report("component_count", component_count, totals_q[0]);
                    void'(totals_q.pop_front());
                end
            end
        end
    end

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Streams binary images into the component counter at several row widths,
// with random idle cycles on both sides, and checks each total
// ---------------------------------------------------------------------------
module tb;

    import bicc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  pixel_group;
    logic        end_of_image;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] component_count;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;
    int          errors;
    int          pending;
    int          sent;
    int          cur_width;
    bit          calm;
    bit          hold_go;
    bit          hold_done;

    binary_image_component_counter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_group     (pixel_group),
        .end_of_image    (end_of_image),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .component_count (component_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    bicc_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_group     (pixel_group),
        .end_of_image    (end_of_image),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .component_count (component_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .errors          (errors),
        .pending         (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("binary_image_component_counter_core verification failed");
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial
    begin
        int held;
        out_ready = 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                held = 0;
                while (held < 3000)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_done = 1;
            end
            else if (!calm && $urandom_range(99) < 24) out_ready <= 1'b0;
            else out_ready <= 1'b1;
        end
    end

    function automatic int cols_of(int v);
        int w;
        w = v & ~3;
        if (w < 4) w = 4;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    task automatic send(input logic [3:0] g, input logic last);
        if (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_group <= g;
        end_of_image <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // wait for all totals and for any row end still in flight
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12 * cols_of(cur_width) + 300) @(posedge clk);
    endtask

    task automatic set_width(input int v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 13'(v);
        cur_width = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one image: density in percent, optionally ending part way into a row
    task automatic send_image(input int rows, input int density, input bit cut);
        int groups;
        int stop;
        logic [3:0] g;
        groups = cols_of(cur_width) / 4;
        for (int r = 0; r < rows; r++)
        begin
            stop = (r == rows - 1 && cut) ? $urandom_range(1, groups) : groups;
            for (int c = 0; c < stop; c++)
            begin
                for (int b = 0; b < 4; b++) g[b] = ($urandom_range(99) < density);
                send(g, (r == rows - 1) && (c == stop - 1));
            end
        end
    endtask

    // stimulus
    initial
    begin
        int widths[8];
        int img;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_group = '0;
        end_of_image = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        calm = 0;
        hold_go = 0;
        sent = 0;
        cur_width = 4096;
        widths = '{4, 8, 12, 16, 24, 32, 64, 100};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-width row ended at once: solid, empty and split
        send(4'hF, 1'b1);
        send(4'h0, 1'b1);
        send(4'b1001, 1'b1);
        // widths below the minimum, above the maximum, not a multiple of four
        set_width(0);
        send(4'b1010, 1'b0);
        send(4'b0101, 1'b0);
        send(4'b1010, 1'b1);
        set_width(8191);
        send(4'b0110, 1'b1);
        set_width(7);
        send(4'b1111, 1'b0);
        send(4'b0000, 1'b0);
        send(4'b1111, 1'b1);
        // end in mid row, then a width change inside an image
        set_width(16);
        send(4'b1011, 1'b0);
        send(4'b0001, 1'b0);
        send(4'b1000, 1'b0);
        send(4'b0001, 1'b0);
        send(4'b1100, 1'b1);
        send(4'b1100, 1'b0);
        send(4'b0011, 1'b0);
        send(4'b1000, 1'b0);
        send(4'b0001, 1'b0);
        set_width(8);
        send(4'b1101, 1'b0);
        send(4'b1011, 1'b1);

        // long hold-off on the result side with one-group images
        set_width(4);
        hold_go = 1;
        for (img = 0; img < 30; img++) send($urandom_range(15), 1'b1);

        // random images across several widths
        img = 0;
        while (sent < 1300)
        begin
            if (img % 6 == 0)
            begin
                set_width(widths[$urandom_range(7)] + (($urandom_range(9) == 0) ? 2 : 0));
                calm = ($urandom_range(4) == 0);
            end
            send_image($urandom_range(1, 8), $urandom_range(99), $urandom_range(3) == 0);
            img++;
        end

        // end of run
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12 * cols_of(cur_width) + 300) @(posedge clk);
        if (errors == 0)
            $display("binary_image_component_counter_core verification clean");
        else
            $display("binary_image_component_counter_core verification failed");
        $finish;
    end

endmodule
